>>> rtl/core/page_id_allocator_and_map_top_macros.svh
// ----------------------------------------------------------------------------
// Page id allocator assertion macros
// Shared concurrent assertion forms used by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef PAGE_ID_ALLOCATOR_AND_MAP_TOP_MACROS_SVH
`define PAGE_ID_ALLOCATOR_AND_MAP_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PIAM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PIAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/piam_pkg.sv
// ----------------------------------------------------------------------------
// Page id allocator package
// Sizes, operation and status codes, and control types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package piam_pkg;

    // Table geometry. SEGMENT_SLOTS is a power of two.
    localparam int SEGMENT_SLOTS = 1024;
    localparam int SEGMENT_COUNT = 64;
    localparam int FREE_DEPTH    = 1024;
    localparam int ENTRY_BITS    = 48;

    localparam int ID_W       = 16;
    localparam int NEXT_W     = ID_W + 1;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int SEG_CNT_W  = 7;
    localparam int ENTRY_W    = ENTRY_BITS + 1;
    localparam int SEG_SHIFT  = $clog2(SEGMENT_SLOTS);
    localparam int SEG_IDX_W  = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int FREE_AW    = $clog2(FREE_DEPTH);
    localparam int FREE_CNT_W = $clog2(FREE_DEPTH + 1);
    localparam int CFG_IDX_W  = 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd0;
    localparam logic [OP_W-1:0] OP_STORE    = 3'd1;
    localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE     = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE_ID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_PAGE_ID = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
    } piam_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
    } piam_stat_t;

    // True when the page number falls in an existing segment slot.
    function automatic logic seg_in_range(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] seg;
        seg = id >> SEG_SHIFT;
        return seg < ID_W'(SEGMENT_COUNT);
    endfunction

    // Segment index of a page number.
    function automatic logic [SEG_IDX_W-1:0] seg_index(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] seg;
        seg = id >> SEG_SHIFT;
        return seg[SEG_IDX_W-1:0];
    endfunction

endpackage

>>> rtl/core/piam_ctrl.sv
// ----------------------------------------------------------------------------
// Page id allocator controller
// Sequences the table clearing pass and the accept and execute steps of each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_id_allocator_and_map_top_macros.svh"

module piam_ctrl
    import piam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  piam_stat_t dp_stat,
    output piam_cmd_t  dp_cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // Next state: clear once after reset, then accept and execute items.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (dp_stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        dp_cmd.clear_en = (state_reg == ST_CLEAR);
        dp_cmd.accept   = (state_reg == ST_IDLE) && start;
        dp_cmd.exec     = (state_reg == ST_EXEC);
    end

    // State and result strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    `PIAM_ASSERT_IMPL(a_done_follows_exec, done_reg, $past(state_reg == ST_EXEC), "result strobe without execution")
    `PIAM_ASSERT_NEXT(a_exec_one_cycle, state_reg == ST_EXEC, state_reg == ST_IDLE, "execution took more than one cycle")
    `PIAM_ASSERT_NEXT(a_clear_once, state_reg != ST_CLEAR, state_reg != ST_CLEAR, "clearing pass entered again")

endmodule

>>> rtl/core/piam_datapath.sv
// ----------------------------------------------------------------------------
// Page id allocator datapath
// Entry table, free stack, segment map, counters and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_id_allocator_and_map_top_macros.svh"

module piam_datapath
    import piam_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  piam_cmd_t              dp_cmd,
    output piam_stat_t             dp_stat,
    input  logic [OP_W-1:0]        operation,
    input  logic [ID_W-1:0]        page_id,
    input  logic [ENTRY_BITS-1:0]  entry_value,
    input  logic                   entry_unloaded,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [NEXT_W-1:0]      cfg_data,
    output logic [ENTRY_BITS-1:0]  read_value,
    output logic                   read_unloaded,
    output logic [ID_W-1:0]        new_page_id,
    output logic [NEXT_W-1:0]      next_fresh_id,
    output logic [SEG_CNT_W-1:0]   segments_in_use,
    output logic [STATUS_W-1:0]    status
);

    // Memories.
    logic [ENTRY_W-1:0] entry_mem [0:(1 << ID_W)-1];
    logic [ID_W-1:0]    stack_mem [0:FREE_DEPTH-1];

    // Control state.
    logic [NEXT_W-1:0]        next_id_reg, next_id_next;
    logic [ID_W-1:0]          invalid_id_reg;
    logic [FREE_CNT_W-1:0]    free_count_reg, free_count_next;
    logic [SEGMENT_COUNT-1:0] seg_map_reg, seg_map_next;
    logic [SEG_CNT_W-1:0]     seg_count_reg, seg_count_next;
    logic [ID_W-1:0]          clear_addr_reg;

    // Captured item and read data.
    logic [OP_W-1:0]       op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [ENTRY_BITS-1:0] val_reg;
    logic                  unl_reg;
    logic [ENTRY_W-1:0]    entry_rd_reg;
    logic [ID_W-1:0]       stack_rd_reg;

    // Result registers.
    logic [ENTRY_BITS-1:0] read_value_reg;
    logic                  read_unloaded_reg;
    logic [ID_W-1:0]       new_page_id_reg;
    logic [STATUS_W-1:0]   status_reg;

    // Execution signals.
    logic [STATUS_W-1:0]   status_c;
    logic [ENTRY_BITS-1:0] rd_val_c;
    logic                  rd_unl_c;
    logic [ID_W-1:0]       new_id_c;
    logic                  touch_en;
    logic [ID_W-1:0]       touch_id;
    logic                  ent_exec_we;
    logic [ENTRY_W-1:0]    ent_exec_wdata;
    logic                  stk_we;
    logic [NEXT_W-1:0]     fresh_id;
    logic                  id_invalid;
    logic                  id_seg_ok;
    logic                  ent_we;
    logic [ID_W-1:0]       ent_waddr;
    logic [ENTRY_W-1:0]    ent_wdata;
    logic [FREE_AW-1:0]    stk_raddr;
    logic [FREE_CNT_W-1:0] free_top;
    logic                  seg_new;
    logic [SEG_IDX_W-1:0]  touch_idx;

    assign id_invalid = (id_reg == invalid_id_reg);
    assign id_seg_ok  = seg_in_range(id_reg);

    // The fresh number skips the reserved invalid number.
    assign fresh_id = next_id_reg + NEXT_W'(next_id_reg == {1'b0, invalid_id_reg});

    // Operation decode and result computation during the execute cycle.
    always_comb
    begin
        status_c        = STATUS_OK;
        rd_val_c        = '0;
        rd_unl_c        = 1'b0;
        new_id_c        = '0;
        next_id_next    = next_id_reg;
        free_count_next = free_count_reg;
        touch_en        = 1'b0;
        touch_id        = id_reg;
        ent_exec_we     = 1'b0;
        ent_exec_wdata  = '0;
        stk_we          = 1'b0;

        if (op_reg inside {OP_LOOKUP, OP_STORE, OP_FREE})
        begin
            if (id_invalid)
            begin
                status_c = STATUS_INVALID;
            end
            else if (!id_seg_ok)
            begin
                status_c = STATUS_RANGE;
            end
        end

        case (op_reg)
            OP_LOOKUP:
            begin
                if (status_c == STATUS_OK)
                begin
                    rd_val_c = entry_rd_reg[ENTRY_BITS-1:0];
                    rd_unl_c = entry_rd_reg[ENTRY_BITS];
                end
            end
            OP_STORE:
            begin
                if (status_c == STATUS_OK)
                begin
                    touch_en       = 1'b1;
                    ent_exec_we    = 1'b1;
                    ent_exec_wdata = {(val_reg != '0) && unl_reg, val_reg};
                end
            end
            OP_ALLOCATE:
            begin
                if (free_count_reg != '0)
                begin
                    free_count_next = free_count_reg - FREE_CNT_W'(1);
                    touch_en        = 1'b1;
                    touch_id        = stack_rd_reg;
                    new_id_c        = stack_rd_reg;
                end
                else if (fresh_id[ID_W])
                begin
                    status_c = STATUS_EXHAUSTED;
                end
                else if (!seg_in_range(fresh_id[ID_W-1:0]))
                begin
                    status_c = STATUS_RANGE;
                end
                else
                begin
                    next_id_next = fresh_id + NEXT_W'(1);
                    touch_en     = 1'b1;
                    touch_id     = fresh_id[ID_W-1:0];
                    new_id_c     = fresh_id[ID_W-1:0];
                end
            end
            OP_FREE:
            begin
                if (status_c == STATUS_OK)
                begin
                    if (free_count_reg >= FREE_CNT_W'(FREE_DEPTH))
                    begin
                        status_c = STATUS_FULL;
                    end
                    else
                    begin
                        touch_en        = 1'b1;
                        ent_exec_we     = 1'b1;
                        stk_we          = 1'b1;
                        free_count_next = free_count_reg + FREE_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // Query and unused codes change nothing.
            end
        endcase
    end

    // Segment creation and the running count of segments in use.
    always_comb
    begin
        touch_idx      = seg_index(touch_id);
        seg_new        = touch_en && !seg_map_reg[touch_idx];
        seg_map_next   = seg_map_reg;
        seg_count_next = seg_count_reg;
        if (seg_new)
        begin
            seg_map_next[touch_idx] = 1'b1;
            seg_count_next          = seg_count_reg + SEG_CNT_W'(1);
        end
    end

    // Entry write port: clearing pass or item write.
    assign ent_we    = dp_cmd.clear_en || (dp_cmd.exec && ent_exec_we);
    assign ent_waddr = dp_cmd.clear_en ? clear_addr_reg : id_reg;
    assign ent_wdata = dp_cmd.clear_en ? '0 : ent_exec_wdata;

    // Free stack top address for allocate.
    assign free_top  = free_count_reg - FREE_CNT_W'(1);
    assign stk_raddr = free_top[FREE_AW-1:0];

    // Entry table memory.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        if (dp_cmd.accept)
        begin
            entry_rd_reg <= entry_mem[page_id];
        end
    end

    // Free stack memory.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec && stk_we)
        begin
            stack_mem[free_count_reg[FREE_AW-1:0]] <= id_reg;
        end
        if (dp_cmd.accept)
        begin
            stack_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Item capture and result registers.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            op_reg  <= operation;
            id_reg  <= page_id;
            val_reg <= entry_value;
            unl_reg <= entry_unloaded;
        end
        if (dp_cmd.exec)
        begin
            read_value_reg    <= rd_val_c;
            read_unloaded_reg <= rd_unl_c;
            new_page_id_reg   <= new_id_c;
            status_reg        <= status_c;
        end
    end

    // Counters, segment map, configuration and clearing address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg    <= NEXT_W'(1);
            invalid_id_reg <= '0;
            free_count_reg <= '0;
            seg_map_reg    <= '0;
            seg_count_reg  <= '0;
            clear_addr_reg <= '0;
        end
        else
        begin
            if (dp_cmd.clear_en)
            begin
                clear_addr_reg <= clear_addr_reg + ID_W'(1);
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_START_PAGE_ID:
                    begin
                        next_id_reg    <= cfg_data;
                        free_count_reg <= '0;
                    end
                    CFG_INVALID_PAGE_ID:
                    begin
                        invalid_id_reg <= cfg_data[ID_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (dp_cmd.exec)
            begin
                next_id_reg    <= next_id_next;
                free_count_reg <= free_count_next;
                seg_map_reg    <= seg_map_next;
                seg_count_reg  <= seg_count_next;
            end
        end
    end

    assign dp_stat.clear_done = (clear_addr_reg == '1);

    assign read_value      = read_value_reg;
    assign read_unloaded   = read_unloaded_reg;
    assign new_page_id     = new_page_id_reg;
    assign next_fresh_id   = next_id_reg;
    assign segments_in_use = seg_count_reg;
    assign status          = status_reg;

    `PIAM_ASSERT_IMPL(a_free_bound, 1'b1, free_count_reg <= FREE_CNT_W'(FREE_DEPTH), "free count above stack depth")
    `PIAM_ASSERT_IMPL(a_seg_count_match, 1'b1, seg_count_reg == SEG_CNT_W'($countones(seg_map_reg)), "segment count out of step with map")
    `PIAM_ASSERT_IMPL(a_seg_count_bound, 1'b1, seg_count_reg <= SEG_CNT_W'(SEGMENT_COUNT), "segment count above segment total")

endmodule

>>> rtl/core/page_id_allocator_and_map_top.sv
// ----------------------------------------------------------------------------
// Page id allocator and map
// Page mapping table with a last-in first-out free list of page numbers.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising edge where start is high and busy is low. It
// carries an operation (lookup, store, allocate, free or segment query), a
// page number, and an entry word with its unloaded flag.
// For each item the entry table and free stack top are read as it is taken,
// then the execute step decides and writes back. The result registers are
// loaded at the end of the execute step and done is high for exactly one
// cycle after that, when the result ports are valid. No item is taken while
// one executes; busy falls as done rises, so a new item may be started in
// the same cycle as a result is shown. The receiver cannot stall; each
// result must be taken on done. Configuration writes use cfg_valid,
// cfg_ready (always high), cfg_index and cfg_data; the user must make them
// only while no item is in flight, which the block does not enforce. After
// reset the block runs a clearing pass over the 65536-entry table, one entry
// per cycle, with busy high; configuration writes are taken in that pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_id_allocator_and_map_top
    import piam_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        operation,
    input  logic [ID_W-1:0]        page_id,
    input  logic [ENTRY_BITS-1:0]  entry_value,
    input  logic                   entry_unloaded,
    output logic                   done,
    output logic [ENTRY_BITS-1:0]  read_value,
    output logic                   read_unloaded,
    output logic [ID_W-1:0]        new_page_id,
    output logic [NEXT_W-1:0]      next_fresh_id,
    output logic [SEG_CNT_W-1:0]   segments_in_use,
    output logic [STATUS_W-1:0]    status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [NEXT_W-1:0]      cfg_data
);

    piam_cmd_t  dp_cmd;
    piam_stat_t dp_stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Controller.
    piam_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd),
        .busy    (busy),
        .done    (done)
    );

    // Datapath.
    piam_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .dp_stat         (dp_stat),
        .operation       (operation),
        .page_id         (page_id),
        .entry_value     (entry_value),
        .entry_unloaded  (entry_unloaded),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .read_value      (read_value),
        .read_unloaded   (read_unloaded),
        .new_page_id     (new_page_id),
        .next_fresh_id   (next_fresh_id),
        .segments_in_use (segments_in_use),
        .status          (status)
    );

endmodule
